/* design/assert_macros.svh */
// Assertion macros used by the classifier back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is high.
`define PCL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also runs during reset.
`define PCL_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCL_ASSERT(lbl, clk, rst, prop, msg)
`define PCL_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

/* design/pcl_pkg.sv */
// Shared types, constants and keyword tables for the login line classifier.
`timescale 1ns / 1ps
package pcl_pkg;

   localparam int SCAN_LIMIT  = 512;
   localparam int NAME_MAX    = 63;
   localparam int STORE_DEPTH = 63;
   localparam int NAME_CAP    = (NAME_MAX < STORE_DEPTH) ? NAME_MAX : STORE_DEPTH;

   localparam int POS_W       = $clog2(SCAN_LIMIT + 1);
   localparam int NAME_W      = $clog2(STORE_DEPTH + 1);
   localparam int BANK_DEPTH  = 2 ** NAME_W;
   localparam int RAM_DEPTH   = 2 * BANK_DEPTH;
   localparam int RAM_AW      = NAME_W + 1;

   localparam int KW_COUNT    = 16;
   localparam int KW_MAX      = 5;
   localparam int KW_IDX_W    = $clog2(KW_MAX);
   localparam int LINE_W      = $clog2(KW_MAX + 1);
   localparam int KW_USER     = 0;
   localparam int KW_PASS     = 1;

   localparam int JOB_Q_DEPTH = 2;
   localparam int JOB_Q_PW    = $clog2(JOB_Q_DEPTH);
   localparam int JOB_Q_CW    = $clog2(JOB_Q_DEPTH + 1);

   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_SP       = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_UP_A     = 8'h41;
   localparam logic [7:0] CH_UP_Z     = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'd32;
   localparam logic [7:0] CH_NUL      = 8'h00;

   typedef enum logic [1:0] {
      VERDICT_NONE  = 2'd0,
      VERDICT_USER  = 2'd1,
      VERDICT_PASS  = 2'd2,
      VERDICT_OTHER = 2'd3
   } verdict_type;

   typedef struct packed {
      verdict_type       verdict;
      logic [NAME_W-1:0] length;
      logic              bank;
   } job_type;

   // Lower-case keyword text, unused tail bytes are zero.
   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX] = '{
      '{"u", "s", "e", "r", " "},
      '{"p", "a", "s", "s", " "},
      '{"s", "t", "a", "t", CH_NUL},
      '{"l", "i", "s", "t", CH_NUL},
      '{"r", "e", "t", "r", CH_NUL},
      '{"d", "e", "l", "e", CH_NUL},
      '{"n", "o", "o", "p", CH_NUL},
      '{"r", "s", "e", "t", CH_NUL},
      '{"q", "u", "i", "t", CH_NUL},
      '{"t", "o", "p", CH_NUL, CH_NUL},
      '{"u", "i", "d", "l", CH_NUL},
      '{"a", "p", "o", "p", CH_NUL},
      '{"c", "a", "p", "a", CH_NUL},
      '{"s", "t", "l", "s", CH_NUL},
      '{"+", "o", "k", CH_NUL, CH_NUL},
      '{"-", "e", "r", "r", CH_NUL}
   };

   localparam logic [LINE_W-1:0] KW_LEN [KW_COUNT] = '{
      LINE_W'(5), LINE_W'(5), LINE_W'(4), LINE_W'(4),
      LINE_W'(4), LINE_W'(4), LINE_W'(4), LINE_W'(4),
      LINE_W'(4), LINE_W'(3), LINE_W'(4), LINE_W'(4),
      LINE_W'(4), LINE_W'(4), LINE_W'(3), LINE_W'(4)
   };

endpackage

/* design/pcl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pcl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/pcl_front.sv */
// Front end: scans packet bytes, matches keywords, collects the user name, posts jobs.
`timescale 1ns / 1ps
module pcl_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_last_byte,
   output logic                          job_push,
   output pcl_pkg::job_type              job,
   input  logic                          job_done,
   output logic                          wr_en,
   output logic [pcl_pkg::RAM_AW-1:0]    wr_addr,
   output logic [7:0]                    wr_data
);
   import pcl_pkg::*;

   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [KW_COUNT-1:0] alive_ff, alive_in;
   logic                lf_seen_ff, lf_seen_in;
   logic                cr_pend_ff, cr_pend_in;
   logic                started_ff, started_in;
   logic [NAME_W-1:0]   cnt_ff, cnt_in;
   logic [NAME_W-1:0]   trim_ff, trim_in;
   logic [LINE_W-1:0]   line_ff, line_in;
   logic [NAME_W-1:0]   run_ff, run_in;
   logic                bank_ff, bank_in;
   logic [1:0]          busy_ff, busy_in;

   logic                accept;
   logic [7:0]          lc;
   logic                blank;
   logic                store_en;
   verdict_type         verdict;
   logic                found;

   // Two name banks: hold input once both carry packets not yet drained.
   assign req_stall = (busy_ff == 2'd2);
   assign accept    = req_valid && !req_stall;

   assign lc    = (req_data_byte >= CH_UP_A && req_data_byte <= CH_UP_Z) ?
                  req_data_byte + CASE_OFFSET : req_data_byte;
   assign blank = (req_data_byte == CH_SP) || (req_data_byte == CH_TAB);

   always_comb begin
      pos_in     = pos_ff;
      alive_in   = alive_ff;
      lf_seen_in = lf_seen_ff;
      cr_pend_in = cr_pend_ff;
      started_in = started_ff;
      cnt_in     = cnt_ff;
      trim_in    = trim_ff;
      line_in    = line_ff;
      run_in     = run_ff;
      store_en   = 1'b0;
      if (!lf_seen_ff && pos_ff < POS_W'(SCAN_LIMIT)) begin
         if (req_data_byte == CH_LF) begin
            lf_seen_in = 1'b1;
            cr_pend_in = 1'b0;
            line_in    = (pos_ff >= POS_W'(KW_MAX)) ? LINE_W'(KW_MAX) : pos_ff[LINE_W-1:0];
         end else begin
            // A CR not followed by LF counts as a name byte after all.
            if (cr_pend_ff) begin
               trim_in    = run_ff;
               cr_pend_in = 1'b0;
            end
            if (pos_ff < POS_W'(KW_MAX)) begin
               for (int k = 0; k < KW_COUNT; k++) begin
                  if (POS_W'(KW_LEN[k]) > pos_ff &&
                      lc != KW_TEXT[k][pos_ff[KW_IDX_W-1:0]]) begin
                     alive_in[k] = 1'b0;
                  end
               end
            end
            if (alive_in[KW_USER] && pos_ff >= POS_W'(KW_MAX) && (started_ff || !blank)) begin
               started_in = 1'b1;
               if (cnt_ff < NAME_W'(NAME_CAP)) begin
                  store_en = 1'b1;
                  cnt_in   = cnt_ff + 1'b1;
               end
               if (run_ff < NAME_W'(NAME_CAP)) begin
                  run_in = run_ff + 1'b1;
               end
               if (req_data_byte == CH_CR) begin
                  cr_pend_in = 1'b1;
               end else if (!blank) begin
                  trim_in = run_in;
               end
            end
         end
      end
      if (pos_ff < POS_W'(SCAN_LIMIT)) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   // First live keyword that fits within the line wins.
   always_comb begin
      verdict = VERDICT_NONE;
      found   = 1'b0;
      if (lf_seen_in && pos_in >= POS_W'(KW_MAX)) begin
         for (int k = 0; k < KW_COUNT; k++) begin
            if (!found && alive_in[k] && line_in >= KW_LEN[k]) begin
               found   = 1'b1;
               verdict = (k == KW_USER) ? VERDICT_USER :
                         (k == KW_PASS) ? VERDICT_PASS : VERDICT_OTHER;
            end
         end
      end
   end

   assign job_push       = accept && req_last_byte;
   assign job.verdict    = verdict;
   assign job.length     = (verdict == VERDICT_USER) ? trim_in : '0;
   assign job.bank       = bank_ff;

   assign wr_en   = accept && store_en;
   assign wr_addr = {bank_ff, cnt_ff};
   assign wr_data = req_data_byte;

   assign bank_in = job_push ? !bank_ff : bank_ff;
   assign busy_in = busy_ff + {1'b0, job_push} - {1'b0, job_done};

   always_ff @(posedge clock) begin
      if (reset || job_push) begin
         pos_ff     <= '0;
         alive_ff   <= '1;
         lf_seen_ff <= 1'b0;
         cr_pend_ff <= 1'b0;
         started_ff <= 1'b0;
         cnt_ff     <= '0;
         trim_ff    <= '0;
         line_ff    <= '0;
         run_ff     <= '0;
      end else if (accept) begin
         pos_ff     <= pos_in;
         alive_ff   <= alive_in;
         lf_seen_ff <= lf_seen_in;
         cr_pend_ff <= cr_pend_in;
         started_ff <= started_in;
         cnt_ff     <= cnt_in;
         trim_ff    <= trim_in;
         line_ff    <= line_in;
         run_ff     <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= 1'b0;
         busy_ff <= 2'd0;
      end else begin
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

endmodule

/* design/pcl_job_fifo.sv */
// Short job queue between the front end and the result sequencer.
`timescale 1ns / 1ps
module pcl_job_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pcl_pkg::job_type push_job,
   input  logic             pop,
   output logic             empty,
   output pcl_pkg::job_type head
);
   import pcl_pkg::*;

   job_type               q_ff [JOB_Q_DEPTH];
   logic [JOB_Q_PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [JOB_Q_PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [JOB_Q_CW-1:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign head  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == JOB_Q_PW'(JOB_Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == JOB_Q_PW'(JOB_Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + {{(JOB_Q_CW-1){1'b0}}, push} - {{(JOB_Q_CW-1){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* design/pcl_back.sv */
// Back end: takes jobs and sends the verdict and the stored name bytes.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pcl_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  pcl_pkg::job_type           q_head,
   output logic                       q_pop,
   output logic                       job_done,
   output logic                       rd_en,
   output logic [pcl_pkg::RAM_AW-1:0] rd_addr,
   input  logic [7:0]                 rd_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_verdict,
   output logic [7:0]                 rsp_name_byte,
   output logic                       rsp_name_valid,
   output logic [5:0]                 rsp_name_length,
   output logic                       rsp_last_result
);
   import pcl_pkg::*;

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_NAME = 2'b10
   } back_state_type;

   back_state_type    state_ff, state_in;
   job_type           job_ff, job_in;
   logic [NAME_W-1:0] idx_ff, idx_in;
   logic              rd_pend_ff;
   logic              rd_last_ff, rd_last_in;

   logic              rsp_valid_ff, rsp_valid_in;
   verdict_type       rsp_verdict_ff, rsp_verdict_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_nvalid_ff, rsp_nvalid_in;
   logic [5:0]        rsp_len_ff, rsp_len_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rd_addr  = {job_ff.bank, idx_ff};

   always_comb begin
      state_in       = state_ff;
      job_in         = job_ff;
      idx_in         = idx_ff;
      rd_last_in     = rd_last_ff;
      q_pop          = 1'b0;
      job_done       = 1'b0;
      rd_en          = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_nvalid_in  = rsp_nvalid_ff;
      rsp_len_in     = rsp_len_ff;
      rsp_last_in    = rsp_last_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop  = 1'b1;
               job_in = q_head;
               idx_in = '0;
               if (q_head.length == '0) begin
                  rsp_valid_in   = 1'b1;
                  rsp_verdict_in = q_head.verdict;
                  rsp_byte_in    = CH_NUL;
                  rsp_nvalid_in  = 1'b0;
                  rsp_len_in     = '0;
                  rsp_last_in    = 1'b1;
                  job_done       = 1'b1;
               end else begin
                  state_in = BK_NAME;
               end
            end
         end
         BK_NAME: begin
            if (rd_pend_ff) begin
               // Output register was free when the read went out.
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = job_ff.verdict;
               rsp_byte_in    = rd_data;
               rsp_nvalid_in  = 1'b1;
               rsp_len_in     = 6'(job_ff.length);
               rsp_last_in    = rd_last_ff;
               if (rd_last_ff) begin
                  job_done = 1'b1;
                  state_in = BK_IDLE;
               end
            end else if (out_free) begin
               rd_en      = 1'b1;
               idx_in     = idx_ff + 1'b1;
               rd_last_in = ((idx_ff + 1'b1) == job_ff.length);
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff         <= job_in;
      idx_ff         <= idx_in;
      rd_last_ff     <= rd_last_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_nvalid_ff  <= rsp_nvalid_in;
      rsp_len_ff     <= rsp_len_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = rsp_verdict_ff;
   assign rsp_name_byte   = rsp_byte_ff;
   assign rsp_name_valid  = rsp_nvalid_ff;
   assign rsp_name_length = rsp_len_ff;
   assign rsp_last_result = rsp_last_ff;

   `PCL_ASSERT(a_rd_into_free_slot, clock, reset, rd_pend_ff |-> !rsp_valid_ff, "read data would overwrite a held result")
   `PCL_ASSERT(a_done_shows_last, clock, reset, job_done |=> (rsp_valid_ff && rsp_last_ff), "job finished without a final result")
   `PCL_ASSERT(a_idx_in_range, clock, reset, (state_ff == BK_NAME) |-> (idx_ff <= job_ff.length), "name read index past name length")
   `PCL_ASSERT(a_name_only_user, clock, reset, (rsp_valid_ff && rsp_nvalid_ff) |-> (rsp_verdict_ff == VERDICT_USER), "name byte on a non-user verdict")
   `PCL_ASSERT_NR(a_reset_idle, clock, reset |=> (!rd_pend_ff && !rsp_valid_ff && state_ff == BK_IDLE), "back end not idle after reset")

endmodule

/* design/pop3_login_line_classifier_unit.sv */
// Top level of the login line classifier: front end, job queue, name RAM, back end.
//
// Usage:
//  - Input channel req_*: one payload byte per transfer, req_last_byte marks the
//    packet's last byte. A byte can be taken every cycle while req_stall is low.
//  - Result channel rsp_*: at the end of each packet, one result with the verdict,
//    or for a user line with a non-empty name one result per name byte.
//    rsp_last_result marks the packet's final result.
//  - Result path: a verdict-only result passes through the job queue and the output
//    register; the first name byte of a user line also passes the registered name RAM read.
//    Name bytes leave one at a time: each waits for the registered read
//    of the name RAM, issued only once the single output register can take it.
//  - The name RAM holds two banks; req_stall rises while two finished packets are
//    still waiting to be sent, so a third packet waits for the older one to drain.
//  - A stall on rsp_stall holds the output register; the front keeps taking bytes
//    until both banks are in use.
//  - Reset (synchronous, active high) clears packet state, the job queue and the
//    output register; no clearing pass is needed.
`timescale 1ns / 1ps
module pop3_login_line_classifier_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_verdict,
   output logic [7:0] rsp_name_byte,
   output logic       rsp_name_valid,
   output logic [5:0] rsp_name_length,
   output logic       rsp_last_result
);
   import pcl_pkg::*;

   logic              job_push;
   job_type           push_job;
   logic              job_done;
   logic              q_pop;
   logic              q_empty;
   job_type           q_head;
   logic              wr_en;
   logic [RAM_AW-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [RAM_AW-1:0] rd_addr;
   logic [7:0]        rd_data;

   pcl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .job_push      (job_push),
      .job           (push_job),
      .job_done      (job_done),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data)
   );

   pcl_job_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   pcl_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_name_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pcl_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .job_done        (job_done),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_verdict     (rsp_verdict),
      .rsp_name_byte   (rsp_name_byte),
      .rsp_name_valid  (rsp_name_valid),
      .rsp_name_length (rsp_name_length),
      .rsp_last_result (rsp_last_result)
   );

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the login line classifier: packet stimulus and result scoreboard.
`timescale 1ns / 1ps
module testbench;
   import pcl_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_FROM  = 300;
   localparam int QUIET_TO    = 1100;
   localparam int IDLE_PCT    = 9;
   localparam int RANDOM_BYTES = 70;
   localparam int DRAIN_CYCLES = 12;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } payload_type;

   typedef struct {
      verdict_type verdict;
      logic [7:0]  name_byte;
      logic        name_valid;
      logic [5:0]  name_length;
      logic        last;
   } login_result_type;

   // prefixes in match order; user and pass carry their trailing space
   string kw_word [KW_COUNT] = '{"user ", "pass ", "stat", "list", "retr", "dele", "noop",
                                 "rset", "quit", "top", "uidl", "apop", "capa", "stls",
                                 "+ok", "-err"};

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_verdict;
   logic [7:0] rsp_name_byte;
   logic       rsp_name_valid;
   logic [5:0] rsp_name_length;
   logic       rsp_last_result;

   payload_type      byte_q [$];
   logic [7:0]       pkt [$];
   login_result_type result_q [$];
   payload_type      next_byte;
   login_result_type want;

   int cycle_count = 0;
   int error_count = 0;
   int bytes_taken = 0;
   int total_bytes = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   // line scanner state
   int          scan_pos = 0;
   logic [15:0] kw_live = 16'hFFFF;
   bit          lf_seen = 1'b0;
   bit          cr_hold = 1'b0;
   bit          name_on = 1'b0;
   logic [7:0]  name_buf [STORE_DEPTH];
   int          name_fill = 0;
   int          name_keep = 0;
   int          line_len = 0;
   int          name_span = 0;

   pop3_login_line_classifier_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_verdict     (rsp_verdict),
      .rsp_name_byte   (rsp_name_byte),
      .rsp_name_valid  (rsp_name_valid),
      .rsp_name_length (rsp_name_length),
      .rsp_last_result (rsp_last_result)
   );

   task automatic report(input string msg);
      $display("%0t: %s", $time, msg);
      error_count++;
   endtask

   // Advance the line scanner by one byte; at packet end queue the expected results.
   task automatic classify_byte(input logic [7:0] b, input logic last);
      logic [7:0]       lc;
      verdict_type      v;
      bit               found;
      bit               blank;
      login_result_type r;
      if (!lf_seen && scan_pos < SCAN_LIMIT) begin
         lc = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_OFFSET : b;
         if (b == CH_LF) begin
            lf_seen = 1'b1;
            cr_hold = 1'b0;
            line_len = scan_pos;
         end else begin
            // a CR followed by something other than LF belongs to the name
            if (cr_hold) begin
               name_keep = (name_span < NAME_CAP) ? name_span : NAME_CAP;
               cr_hold = 1'b0;
            end
            for (int k = 0; k < KW_COUNT; k++)
               if (scan_pos < kw_word[k].len() && lc != kw_word[k][scan_pos])
                  kw_live[k] = 1'b0;
            if (kw_live[KW_USER] && scan_pos >= 5) begin
               blank = (b == CH_SP || b == CH_TAB);
               if (name_on || !blank) begin
                  name_on = 1'b1;
                  if (name_fill < NAME_CAP) begin
                     name_buf[name_fill] = b;
                     name_fill++;
                  end
                  name_span++;
                  if (b == CH_CR)
                     cr_hold = 1'b1;
                  else if (!blank)
                     name_keep = (name_span < NAME_CAP) ? name_span : NAME_CAP;
               end
            end
         end
      end
      if (scan_pos < SCAN_LIMIT)
         scan_pos++;
      if (last) begin
         v = VERDICT_NONE;
         found = 1'b0;
         if (lf_seen && scan_pos >= 5)
            for (int k = 0; k < KW_COUNT; k++)
               if (!found && kw_live[k] && line_len >= kw_word[k].len()) begin
                  found = 1'b1;
                  v = (k == KW_USER) ? VERDICT_USER :
                      (k == KW_PASS) ? VERDICT_PASS : VERDICT_OTHER;
               end
         if (v == VERDICT_USER && name_keep > 0) begin
            for (int k = 0; k < name_keep; k++) begin
               r.verdict = v;
               r.name_byte = name_buf[k];
               r.name_valid = 1'b1;
               r.name_length = 6'(name_keep);
               r.last = (k == name_keep - 1);
               result_q.push_back(r);
            end
         end else begin
            r = '{v, 8'h00, 1'b0, 6'd0, 1'b1};
            result_q.push_back(r);
         end
         scan_pos = 0;
         kw_live = 16'hFFFF;
         lf_seen = 1'b0;
         cr_hold = 1'b0;
         name_on = 1'b0;
         name_fill = 0;
         name_keep = 0;
         line_len = 0;
         name_span = 0;
      end
   endtask

   task automatic put(input logic [7:0] b);
      pkt.push_back(b);
   endtask

   // append text, flipping lower-case letters to upper case at random when mix is set
   task automatic put_text(input string s, input bit mix);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (mix && c >= "a" && c <= "z" && $urandom_range(1) == 1)
            c = c - CASE_OFFSET;
         pkt.push_back(c);
      end
   endtask

   task automatic put_eol(input bit with_cr);
      if (with_cr)
         pkt.push_back(CH_CR);
      pkt.push_back(CH_LF);
   endtask

   task automatic put_blank();
      pkt.push_back(($urandom_range(1) == 1) ? CH_SP : CH_TAB);
   endtask

   function automatic logic [7:0] name_char();
      int         r;
      logic [7:0] v;
      r = $urandom_range(99);
      if (r < 60)
         v = 8'($urandom_range(8'h7E, 8'h21));
      else if (r < 70)
         v = CH_SP;
      else if (r < 75)
         v = CH_TAB;
      else if (r < 80)
         v = CH_CR;
      else begin
         v = 8'($urandom_range(255));
         if (v == CH_LF)
            v = 8'hFF;
      end
      return v;
   endfunction

   task automatic send_packet();
      payload_type p;
      for (int i = 0; i < pkt.size(); i++) begin
         p.data = pkt[i];
         p.last = (i == pkt.size() - 1);
         byte_q.push_back(p);
      end
      pkt.delete();
   endtask

   task automatic make_random_packet();
      int kind;
      int n;
      int k;
      kind = $urandom_range(99);
      if (kind < 40) begin
         put_text(kw_word[KW_USER], 1'b1);
         repeat ($urandom_range(3)) put_blank();
         n = ($urandom_range(19) == 0) ? $urandom_range(80, 50) : $urandom_range(12, 1);
         repeat (n) put(name_char());
         repeat ($urandom_range(3)) put_blank();
         if ($urandom_range(9) != 0)
            put_eol($urandom_range(3) != 0);
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(3, 1)) put(8'($urandom_range(255)));
      end else if (kind < 55) begin
         put_text(kw_word[KW_PASS], 1'b1);
         repeat ($urandom_range(10)) put(name_char());
         put_eol($urandom_range(3) != 0);
      end else if (kind < 80) begin
         k = $urandom_range(KW_COUNT - 1, 2);
         put_text(kw_word[k], 1'b1);
         if ($urandom_range(1) == 1) begin
            put(CH_SP);
            repeat ($urandom_range(4, 1)) put(8'($urandom_range(8'h7E, 8'h21)));
         end
         put_eol($urandom_range(3) != 0);
      end else if (kind < 88) begin
         // keyword with one character corrupted
         k = $urandom_range(KW_COUNT - 1);
         put_text(kw_word[k], 1'b1);
         pkt[$urandom_range(pkt.size() - 1)] = 8'($urandom_range(255));
         repeat ($urandom_range(3)) put(name_char());
         put_eol($urandom_range(1) == 1);
      end else if (kind < 93) begin
         k = $urandom_range(KW_COUNT - 1);
         put_text(kw_word[k].substr(0, $urandom_range(2)), 1'b1);
         if ($urandom_range(1) == 1)
            put(CH_LF);
      end else begin
         repeat ($urandom_range(20, 1)) put(8'($urandom_range(255)));
      end
      send_packet();
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("pop3_login_line_classifier_unit regression: fail");
         $finish;
      end
   end

   // sender: note each transfer, then offer the next byte or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            classify_byte(req_data_byte, req_last_byte);
            bytes_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (byte_q.size() != 0 &&
                !((cycle_count < QUIET_FROM || cycle_count >= QUIET_TO) &&
                  $urandom_range(99) < IDLE_PCT)) begin
               next_byte = byte_q.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= next_byte.data;
               req_last_byte <= next_byte.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls plus one long hold midway so both name banks fill
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!hold_done && total_bytes > 0 && bytes_taken >= total_bytes / 2) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (cycle_count < QUIET_FROM || cycle_count >= QUIET_TO) &&
                      ($urandom_range(99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (result_q.size() == 0) begin
            report($sformatf("unexpected result: verdict %0d name byte %h last %b",
                             rsp_verdict, rsp_name_byte, rsp_last_result));
         end else begin
            want = result_q.pop_front();
            if (rsp_verdict !== want.verdict)
               report($sformatf("verdict: got %0d, expected %0d", rsp_verdict, want.verdict));
            if (rsp_name_byte !== want.name_byte)
               report($sformatf("name byte: got %h, expected %h", rsp_name_byte,
                                want.name_byte));
            if (rsp_name_valid !== want.name_valid)
               report($sformatf("name valid: got %b, expected %b", rsp_name_valid,
                                want.name_valid));
            if (rsp_name_length !== want.name_length)
               report($sformatf("name length: got %0d, expected %0d", rsp_name_length,
                                want.name_length));
            if (rsp_last_result !== want.last)
               report($sformatf("last result: got %b, expected %b", rsp_last_result,
                                want.last));
         end
      end
   end

   initial begin
      for (int i = 0; i < STORE_DEPTH; i++)
         name_buf[i] = 8'h00;

      // directed packets
      put_text("USER alice", 1'b0); put_eol(1'b1); send_packet();
      put_text("user", 1'b1); put(CH_SP); put(CH_TAB); put(CH_SP);
      put_text("Bob.Smith", 1'b0); put(CH_SP); put(CH_TAB); put_eol(1'b1); send_packet();
      put_text("PASS hunter2", 1'b0); put_eol(1'b1); send_packet();
      for (int k = 2; k < KW_COUNT; k++) begin
         put_text(kw_word[k], 1'b1);
         if (k % 3 == 0)
            put_text(" 1", 1'b0);
         put_eol(k % 2 == 0);
         send_packet();
      end
      put_text("USER ", 1'b0); put(CH_SP); put(CH_TAB); put_eol(1'b1); send_packet();
      put_text("USER a", 1'b0); put(CH_CR); put_text("b", 1'b0); put_eol(1'b1);
      send_packet();
      put_text("USER a", 1'b0); put(CH_CR); put_eol(1'b1); send_packet();
      put_text("USER x", 1'b0); put(CH_LF); put_text("ZZZ", 1'b0); send_packet();
      put_text("TOP", 1'b0); put(CH_LF); send_packet();
      put_text("ab", 1'b0); send_packet();
      put_text("USER nobody", 1'b0); send_packet();
      put_text("USERX", 1'b0); put_eol(1'b1); send_packet();
      put_text("USER ", 1'b0); put(8'hFF); put(8'h00); put(8'h80); put(8'h7F);
      put_eol(1'b1); send_packet();
      put_text("USER ", 1'b0);
      repeat (70) put(8'($urandom_range(8'h7A, 8'h61)));
      put_eol(1'b1); send_packet();

      total_bytes = byte_q.size();
      while (byte_q.size() < total_bytes + RANDOM_BYTES)
         make_random_packet();
      total_bytes = byte_q.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      wait (bytes_taken == total_bytes);
      while (result_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("pop3_login_line_classifier_unit regression: pass");
      end else begin
         $display("pop3_login_line_classifier_unit regression: fail");
      end
      $finish;
   end

endmodule
